/* src/pfba_pkg.sv */
// Shared constants, codes and types of the page frame bitmap allocator.
`timescale 1ns / 1ps
package pfba_pkg;

  localparam int NumFramesDef  = 1048576;
  localparam int FrameBytesDef = 4096;
  localparam int WordBitsDef   = 64;
  localparam int NumWordsDef   = (NumFramesDef + WordBitsDef - 1) / WordBitsDef;
  localparam int BitIdxW       = 6;
  localparam int AddrW         = 32;
  localparam int LenW          = 33;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_OOM    = 2'd1,
    STATUS_BEYOND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RANGE,
    ST_ALLOC,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic               found;
    logic [BitIdxW-1:0] bit_idx;
  } word_stat_t;

endpackage

/* src/page_frame_bitmap_allocator_core.sv */
// Top level of the page frame bitmap allocator: sequencer, bitmap RAM and result register.
//
// One bit per page frame is kept in a RAM of NUM_FRAMES / WORD_BITS words; a set bit marks
// a used frame. The input channel (in_valid_i / in_stall_o) carries one command beat:
// add a free region, allocate the lowest free frame, or free the frame holding an address.
// Every command returns exactly one result beat on the output channel (out_valid_o /
// out_stall_i) with the frame address and a status.
// Commands are processed one at a time. The bitmap RAM is read one word per cycle and each
// modified word is written back in the cycle after its read. The words touched are the
// words of the region for add, one word for free, and the words scanned up to the first
// free frame for allocate (at most NUM_FRAMES / WORD_BITS, 16384 by default). An empty add
// region, a free beyond the store and an unknown command touch no word.
// After reset a clearing pass writes every RAM word to all used, one word per cycle;
// in_stall_o is high during it.
// The result sits in an output register, and while the receiver stalls it holds there; the
// next command is still accepted and processed, and waits for the output register to free.
`timescale 1ns / 1ps
module page_frame_bitmap_allocator_core #(
  parameter int NUM_FRAMES  = pfba_pkg::NumFramesDef,
  parameter int FRAME_BYTES = pfba_pkg::FrameBytesDef,
  parameter int WORD_BITS   = pfba_pkg::WordBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 command_i,
  input  logic [pfba_pkg::AddrW-1:0] byte_address_i,
  input  logic [pfba_pkg::LenW-1:0]  region_length_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pfba_pkg::AddrW-1:0] frame_address_o,
  output logic [1:0]                 status_o
);

  localparam int NumWords = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int Waw      = $clog2(NumWords);
  localparam int Hww      = Waw + 1;
  localparam int Ws       = $clog2(WORD_BITS);
  localparam int FbShift  = $clog2(FRAME_BYTES);
  localparam int Cw       = pfba_pkg::LenW + 1;
  localparam int LastCnt  = NUM_FRAMES - (NumWords - 1) * WORD_BITS;
  localparam logic [Waw-1:0]       LastWord = Waw'(NumWords - 1);
  localparam logic [WORD_BITS-1:0] FullWord = '1;
  localparam logic [WORD_BITS-1:0] LastMask = FullWord >> (WORD_BITS - LastCnt);
  localparam logic [Cw-1:0]        NumFramesW = Cw'(NUM_FRAMES);

  pfba_pkg::state_e state_q, state_d;

  logic [Waw-1:0]                clr_w_q, clr_w_d;
  logic [Waw-1:0]                rd_w_q, rd_w_d;
  logic                          rd_more_q, rd_more_d;
  logic                          pend_q, pend_d;
  logic [Waw-1:0]                pend_w_q, pend_w_d;
  logic [Waw-1:0]                lo_w_q, lo_w_d;
  logic [Ws-1:0]                 lo_b_q, lo_b_d;
  logic [Hww-1:0]                hi_w_q, hi_w_d;
  logic [Ws-1:0]                 hi_b_q, hi_b_d;
  logic [Waw-1:0]                last_w_q, last_w_d;
  logic [pfba_pkg::AddrW-1:0]    res_frame_q, res_frame_d;
  pfba_pkg::status_e             res_status_q, res_status_d;
  logic                          out_valid_q, out_valid_d;
  logic [pfba_pkg::AddrW-1:0]    out_frame_q, out_frame_d;
  pfba_pkg::status_e             out_status_q, out_status_d;

  logic                          in_acc;
  logic                          out_acc;
  logic                          out_free;
  logic [Cw-1:0]                 start_f;
  logic [Cw-1:0]                 end_f;
  logic [Cw-1:0]                 end_c;
  logic                          add_go;
  logic                          beyond;
  logic [Cw-1:0]                 lo_f;
  logic [Cw-1:0]                 hi_f;
  logic [Cw-1:0]                 hi_m1;
  logic [Waw-1:0]                end_w;

  logic                          ram_we;
  logic [Waw-1:0]                ram_waddr;
  logic [WORD_BITS-1:0]          ram_wdata;
  logic                          ram_re;
  logic [WORD_BITS-1:0]          ram_rdata;

  logic [WORD_BITS-1:0]          mask_lo;
  logic [WORD_BITS-1:0]          mask_hi;
  logic [WORD_BITS-1:0]          valid_mask;
  logic [WORD_BITS-1:0]          unit_wdata;
  pfba_pkg::word_stat_t          unit_stat;
  logic [Waw+Ws+FbShift-1:0]     found_addr;
  logic                          range_done;
  logic                          alloc_found;
  logic                          alloc_oom;

  assign in_stall_o = (state_q != pfba_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign start_f = Cw'(byte_address_i) >> FbShift;
  assign end_f   = (Cw'(byte_address_i) + Cw'(region_length_i)) >> FbShift;
  assign end_c   = (end_f > NumFramesW) ? NumFramesW : end_f;
  assign add_go  = start_f < end_c;
  assign beyond  = start_f >= NumFramesW;
  assign lo_f    = start_f;
  assign hi_f    = (command_i == pfba_pkg::CMD_FREE) ? (start_f + Cw'(1)) : end_c;
  assign hi_m1   = hi_f - Cw'(1);

  assign end_w = (state_q == pfba_pkg::ST_ALLOC) ? LastWord : last_w_q;

  assign mask_lo    = (pend_w_q == lo_w_q) ? (FullWord << lo_b_q) : FullWord;
  assign mask_hi    = ({1'b0, pend_w_q} == hi_w_q) ? ~(FullWord << hi_b_q) : FullWord;
  assign valid_mask = (pend_w_q == LastWord) ? LastMask : FullWord;

  pfba_word_unit #(
    .WORD_BITS(WORD_BITS)
  ) u_word_unit (
    .alloc_i     (state_q == pfba_pkg::ST_ALLOC),
    .rdata_i     (ram_rdata),
    .clr_mask_i  (mask_lo & mask_hi),
    .valid_mask_i(valid_mask),
    .wdata_o     (unit_wdata),
    .stat_o      (unit_stat)
  );

  assign found_addr  = {pend_w_q, unit_stat.bit_idx[Ws-1:0], {FbShift{1'b0}}};
  assign range_done  = (state_q == pfba_pkg::ST_RANGE) && pend_q && (pend_w_q == last_w_q);
  assign alloc_found = (state_q == pfba_pkg::ST_ALLOC) && pend_q && unit_stat.found;
  assign alloc_oom   = (state_q == pfba_pkg::ST_ALLOC) && pend_q && !unit_stat.found &&
                       (pend_w_q == LastWord);

  pfba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NumWords)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_w_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      pfba_pkg::ST_CLEAR: begin
        if (clr_w_q == LastWord) begin
          state_d = pfba_pkg::ST_IDLE;
        end
      end
      pfba_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (command_i)
            pfba_pkg::CMD_ADD:   state_d = add_go ? pfba_pkg::ST_RANGE : pfba_pkg::ST_PUSH;
            pfba_pkg::CMD_ALLOC: state_d = pfba_pkg::ST_ALLOC;
            pfba_pkg::CMD_FREE:  state_d = beyond ? pfba_pkg::ST_PUSH : pfba_pkg::ST_RANGE;
            default:             state_d = pfba_pkg::ST_PUSH;
          endcase
        end
      end
      pfba_pkg::ST_RANGE: begin
        if (range_done) begin
          state_d = pfba_pkg::ST_PUSH;
        end
      end
      pfba_pkg::ST_ALLOC: begin
        if (alloc_found || alloc_oom) begin
          state_d = pfba_pkg::ST_PUSH;
        end
      end
      pfba_pkg::ST_PUSH: begin
        if (out_free) begin
          state_d = pfba_pkg::ST_IDLE;
        end
      end
      default: state_d = pfba_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_w_d      = clr_w_q;
    rd_w_d       = rd_w_q;
    rd_more_d    = rd_more_q;
    pend_d       = pend_q;
    pend_w_d     = pend_w_q;
    lo_w_d       = lo_w_q;
    lo_b_d       = lo_b_q;
    hi_w_d       = hi_w_q;
    hi_b_d       = hi_b_q;
    last_w_d     = last_w_q;
    res_frame_d  = res_frame_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_acc;
    out_frame_d  = out_frame_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = pend_w_q;
    ram_wdata    = unit_wdata;
    ram_re       = 1'b0;
    case (state_q)
      pfba_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_w_q;
        ram_wdata = FullWord;
        clr_w_d   = clr_w_q + Waw'(1);
      end
      pfba_pkg::ST_IDLE: begin
        lo_w_d       = Waw'(lo_f >> Ws);
        lo_b_d       = lo_f[Ws-1:0];
        hi_w_d       = Hww'(hi_f >> Ws);
        hi_b_d       = hi_f[Ws-1:0];
        last_w_d     = Waw'(hi_m1 >> Ws);
        rd_w_d       = (command_i == pfba_pkg::CMD_ALLOC) ? '0 : Waw'(lo_f >> Ws);
        rd_more_d    = 1'b1;
        pend_d       = 1'b0;
        res_frame_d  = '0;
        res_status_d = (command_i == pfba_pkg::CMD_FREE && beyond) ?
                       pfba_pkg::STATUS_BEYOND : pfba_pkg::STATUS_OK;
      end
      pfba_pkg::ST_RANGE, pfba_pkg::ST_ALLOC: begin
        ram_re    = rd_more_q;
        rd_w_d    = rd_w_q + Waw'(1);
        rd_more_d = rd_more_q && (rd_w_q != end_w);
        pend_d    = rd_more_q;
        pend_w_d  = rd_w_q;
        if (state_q == pfba_pkg::ST_RANGE) begin
          ram_we = pend_q;
        end else if (alloc_found) begin
          ram_we       = 1'b1;
          res_frame_d  = pfba_pkg::AddrW'(found_addr);
          res_status_d = pfba_pkg::STATUS_OK;
        end else if (alloc_oom) begin
          res_frame_d  = '0;
          res_status_d = pfba_pkg::STATUS_OOM;
        end
      end
      pfba_pkg::ST_PUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_frame_d  = res_frame_q;
          out_status_d = res_status_q;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfba_pkg::ST_CLEAR;
      clr_w_q     <= '0;
      rd_more_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_w_q     <= clr_w_d;
      rd_more_q   <= rd_more_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_w_q       <= rd_w_d;
    pend_w_q     <= pend_w_d;
    lo_w_q       <= lo_w_d;
    lo_b_q       <= lo_b_d;
    hi_w_q       <= hi_w_d;
    hi_b_q       <= hi_b_d;
    last_w_q     <= last_w_d;
    res_frame_q  <= res_frame_d;
    res_status_q <= res_status_d;
    out_frame_q  <= out_frame_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o     = out_valid_q;
  assign frame_address_o = out_frame_q;
  assign status_o        = out_status_q;

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != rd_w_q)
    else $error("bitmap RAM read and write hit the same word in one cycle");

  a_range_word_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pfba_pkg::ST_RANGE && pend_q |-> pend_w_q >= lo_w_q && pend_w_q <= last_w_q)
    else $error("region update touched a word outside the region");

  a_frame_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_address_o[FbShift-1:0] == '0)
    else $error("result frame address is not frame aligned");

  a_error_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != pfba_pkg::STATUS_OK |-> frame_address_o == '0)
    else $error("error result carries a nonzero frame address");

endmodule

/* src/pfba_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module pfba_ram #(
  parameter int WIDTH = pfba_pkg::WordBitsDef,
  parameter int DEPTH = pfba_pkg::NumWordsDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pfba_word_unit.sv */
// Word modify logic: clears a bit range or claims the lowest free frame of one bitmap word.
`timescale 1ns / 1ps
module pfba_word_unit #(
  parameter int WORD_BITS = pfba_pkg::WordBitsDef
) (
  input  logic                 alloc_i,
  input  logic [WORD_BITS-1:0] rdata_i,
  input  logic [WORD_BITS-1:0] clr_mask_i,
  input  logic [WORD_BITS-1:0] valid_mask_i,
  output logic [WORD_BITS-1:0] wdata_o,
  output pfba_pkg::word_stat_t stat_o
);

  logic [WORD_BITS-1:0]         free_bits;
  logic [WORD_BITS-1:0]         lowest;
  logic [pfba_pkg::BitIdxW-1:0] idx;

  assign free_bits = ~rdata_i & valid_mask_i;
  assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) begin
        idx = idx | pfba_pkg::BitIdxW'(i);
      end
    end
  end

  assign wdata_o        = alloc_i ? (rdata_i | lowest) : (rdata_i & ~clr_mask_i);
  assign stat_o.found   = |free_bits;
  assign stat_o.bit_idx = idx;

endmodule

/* tb/sv/page_frame_bitmap_allocator_core_test.sv */
// Self-checking testbench of the page frame bitmap allocator core with its own bitmap predictor.
`timescale 1ns / 1ps
module page_frame_bitmap_allocator_core_test;
  import pfba_pkg::*;

  localparam logic [1:0]  CmdUnknown = 2'd3;
  localparam int unsigned MaxShown   = 10;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [AddrW-1:0] frame_address;
    status_e          status;
  } reply_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       command_i;
  logic [AddrW-1:0] byte_address_i;
  logic [LenW-1:0]  region_length_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [AddrW-1:0] frame_address_o;
  logic [1:0]       status_o;

  logic [WordBitsDef-1:0] bitmap_words [NumWordsDef];
  reply_t                 predicted_replies [$];
  logic [AddrW-1:0]       granted_frames [$];
  int unsigned            mismatch_count = 0;
  bit                     quiet_source = 1'b0;
  bit                     quiet_sink = 1'b0;
  bit                     sink_hold_request = 1'b0;
  int unsigned            sink_wait = 0;
  int unsigned            sink_hold_left = 0;

  page_frame_bitmap_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .byte_address_i  (byte_address_i),
    .region_length_i (region_length_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_address_o (frame_address_o),
    .status_o        (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void release_frames(longint unsigned first, longint unsigned stop);
    longint unsigned f;
    f = first;
    while (f < stop) begin
      if ((f % WordBitsDef) == 0 && (stop - f) >= WordBitsDef) begin
        bitmap_words[f / WordBitsDef] = '0;
        f += WordBitsDef;
      end else begin
        bitmap_words[f / WordBitsDef][f % WordBitsDef] = 1'b0;
        f++;
      end
    end
  endfunction

  function automatic bit claim_lowest_frame(output longint unsigned frame);
    frame = 0;
    for (int w = 0; w < NumWordsDef; w++) begin
      if (bitmap_words[w] != '1) begin
        for (int b = 0; b < WordBitsDef; b++) begin
          if (!bitmap_words[w][b]) begin
            bitmap_words[w][b] = 1'b1;
            frame = 64'(w) * WordBitsDef + b;
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic reply_t apply_command(logic [1:0] command, logic [AddrW-1:0] address,
                                           logic [LenW-1:0] length);
    reply_t          reply;
    longint unsigned first;
    longint unsigned stop;
    longint unsigned frame;
    reply.frame_address = '0;
    reply.status        = STATUS_OK;
    case (command)
      CMD_ADD: begin
        first = 64'(address) / FrameBytesDef;
        stop  = (64'(address) + 64'(length)) / FrameBytesDef;
        if (stop > NumFramesDef) stop = NumFramesDef;
        if (first < stop) release_frames(first, stop);
      end
      CMD_ALLOC: begin
        if (claim_lowest_frame(frame)) begin
          reply.frame_address = AddrW'(frame * FrameBytesDef);
        end else begin
          reply.status = STATUS_OOM;
        end
      end
      CMD_FREE: begin
        frame = 64'(address) / FrameBytesDef;
        if (frame >= NumFramesDef) begin
          reply.status = STATUS_BEYOND;
        end else begin
          release_frames(frame, frame + 1);
        end
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  task automatic send_command(input logic [1:0] command, input logic [AddrW-1:0] address,
                              input logic [LenW-1:0] length);
    int unsigned gap;
    reply_t      reply;
    gap = quiet_source ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    command_i       <= command;
    byte_address_i  <= address;
    region_length_i <= length;
    do @(posedge clk_i); while (in_stall_o);
    reply = apply_command(command, address, length);
    if (command == CMD_ALLOC && reply.status == STATUS_OK) begin
      granted_frames.push_back(reply.frame_address);
    end
    predicted_replies.push_back(reply);
  endtask

  task automatic wait_for_replies();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : reply_check
    reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sink_wait = quiet_sink ? 0 : $urandom_range(0, 19);
      if (predicted_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxShown) begin
          $display("Unexpected reply: frame_address %h, status %0d",
                   frame_address_o, status_o);
        end
      end else begin
        want = predicted_replies.pop_front();
        if (frame_address_o !== want.frame_address || status_o !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MaxShown) begin
            $display("Reply mismatch: frame_address expected %h got %h, status expected %0d got %0d",
                     want.frame_address, frame_address_o, want.status, status_o);
          end
        end
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_request) begin
        sink_hold_request = 1'b0;
        sink_hold_left    = HoldCycles;
      end
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        out_stall_i <= 1'b1;
      end else if (sink_wait > 0) begin
        sink_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic test_empty_store();
    send_command(CMD_ALLOC, 32'h0, 33'h0);
    wait_for_replies();
  endtask

  task automatic test_region_edges();
    send_command(CMD_ADD, 32'h0000_0000, 33'h0);
    send_command(CMD_ADD, 32'h0000_1000, 33'h0_0000_0FFF);
    send_command(CMD_ADD, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
    send_command(CMD_ADD, 32'h0000_1000, 33'h0_0000_1FFF);
    wait_for_replies();
  endtask

  task automatic test_allocation();
    repeat (3) send_command(CMD_ALLOC, 32'h0, 33'h0);
    wait_for_replies();
  endtask

  task automatic test_free();
    send_command(CMD_FREE, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
    send_command(CMD_FREE, 32'h0000_5ABC, 33'h0);
    send_command(CMD_FREE, 32'h0000_5000, 33'h0);
    repeat (2) send_command(CMD_ALLOC, 32'h0, 33'h0);
    wait_for_replies();
  endtask

  task automatic test_unknown_command();
    send_command(CmdUnknown, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
    send_command(CmdUnknown, 32'h0, 33'h0);
    send_command(CMD_ALLOC, 32'h0, 33'h0);
    wait_for_replies();
  endtask

  task automatic test_whole_store();
    send_command(CMD_ADD, 32'h0, 33'h1_0000_0000);
    send_command(CMD_ALLOC, 32'h0, 33'h0);
    send_command(CMD_ADD, 32'h0, 33'h1_FFFF_FFFF);
    send_command(CMD_ALLOC, 32'h0, 33'h0);
    wait_for_replies();
  endtask

  task automatic test_backpressure();
    @(posedge clk_i);
    sink_hold_request = 1'b1;
    quiet_source      = 1'b1;
    for (int n = 0; n < 3; n++) begin
      send_command(CMD_ALLOC, $urandom(), 33'h0);
      send_command(CMD_FREE, $urandom_range(0, 32'h0000_FFFF), 33'h0);
    end
    quiet_source = 1'b0;
    wait_for_replies();
  endtask

  task automatic test_random_traffic();
    int unsigned      pick;
    int unsigned      slot;
    logic [AddrW-1:0] address;
    logic [LenW-1:0]  length;
    for (int n = 0; n < 75; n++) begin
      if (n % 10 == 0) begin
        quiet_source = ($urandom_range(0, 3) == 0);
        quiet_sink   = ($urandom_range(0, 3) == 0);
      end
      pick    = $urandom_range(0, 99);
      address = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 32'h00FF_FFFF);
      length  = {1'($urandom_range(0, 1)), $urandom()};
      if (pick < 30) begin
        if ($urandom_range(0, 29) != 0) length = LenW'($urandom_range(0, 32'h0002_0000));
        send_command(CMD_ADD, address, length);
      end else if (pick < 70) begin
        send_command(CMD_ALLOC, address, length);
      end else if (pick < 95) begin
        if (granted_frames.size() > 0 && $urandom_range(0, 1) == 1) begin
          slot    = $urandom_range(0, granted_frames.size() - 1);
          address = granted_frames[slot] | AddrW'($urandom_range(0, FrameBytesDef - 1));
          granted_frames.delete(slot);
        end
        send_command(CMD_FREE, address, length);
      end else begin
        send_command(CmdUnknown, address, length);
      end
    end
    quiet_source = 1'b0;
    quiet_sink   = 1'b0;
    wait_for_replies();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    command_i       = CMD_ADD;
    byte_address_i  = '0;
    region_length_i = '0;
    foreach (bitmap_words[w]) bitmap_words[w] = '1;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_store();
    test_region_edges();
    test_allocation();
    test_free();
    test_unknown_command();
    test_whole_store();
    test_backpressure();
    test_random_traffic();
    repeat (64) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/pfba_pkg.sv
src/pfba_ram.sv
src/pfba_word_unit.sv
src/page_frame_bitmap_allocator_core.sv
tb/sv/page_frame_bitmap_allocator_core_test.sv
